/* hdl/assert_macros.svh */
// Assertion macros shared by the texture sampler RTL.
// No dependencies; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsw assertion failed");

// next-cycle implication
`define TSW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsw assertion failed");

`endif

/* hdl/tsw_pkg.sv */
// Shared types and constants for the texture sampler.
// No dependencies.
package tsw_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CFG_DW = 9;
  localparam int CFG_IW = 2;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_NEAREST = 2'd1,
    OP_BILIN   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WRAP_REPEAT = 2'd0,
    WRAP_MIRROR = 2'd1,
    WRAP_CLAMP  = 2'd2,
    WRAP_CLAMP3 = 2'd3
  } wrap_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WRAP_U = 2'd2,
    REG_WRAP_V = 2'd3
  } reg_idx_t;

  typedef logic [23:0] coord_t;

endpackage

/* hdl/tsw_in_if.sv */
// Input channel of the texture sampler: write and sample beats.
// No dependencies.
interface tsw_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [15:0]       texel_index;
  logic [31:0]       texel_rgba;
  logic signed [23:0] u_coord;
  logic signed [23:0] v_coord;

  modport source (output valid, op, texel_index, texel_rgba, u_coord, v_coord,
                  input ready);
  modport sink (input valid, op, texel_index, texel_rgba, u_coord, v_coord,
                output ready);
endinterface

/* hdl/tsw_out_if.sv */
// Output channel of the texture sampler: one filtered RGBA beat per sample.
// No dependencies.
interface tsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

/* hdl/texture_sample_wrap_bilinear.sv */
// Texture sampler top level: RGBA8 texel store, coordinate wrap, nearest or
// bilinear filter. Depends on tsw_pkg, tsw_in_if, tsw_out_if, tsw_ram and
// assert_macros.svh.
//
// Takes one beat per clock (write or sample) and returns one RGBA beat per
// sample from the output register. Throughput is one beat per cycle while
// the output beat is not held: the four bilinear taps come from two copies
// of the texel store, each with two read ports, and every write beat updates
// both copies. The pipeline stalls as a whole only while the output beat is held.
module texture_sample_wrap_bilinear #(
  parameter int MAX_WIDTH  = tsw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tsw_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  tsw_in_if.sink                    in_ch,
  tsw_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tsw_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tsw_pkg::CFG_DW-1:0] cfg_data
);
  import tsw_pkg::*;
  `include "assert_macros.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int SXW   = $clog2(MAX_WIDTH + 1);
  localparam int SYW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (SXW > CFG_DW) ? SXW : CFG_DW;
  localparam int CH    = (SYW > CFG_DW) ? SYW : CFG_DW;

  // configuration
  logic [CFG_DW-1:0] tex_width, tex_height;
  wrap_t wrap_u, wrap_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= CFG_DW'(256);
      tex_height <= CFG_DW'(256);
      wrap_u     <= WRAP_REPEAT;
      wrap_v     <= WRAP_REPEAT;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  tex_width  <= cfg_data;
        REG_HEIGHT: tex_height <= cfg_data;
        REG_WRAP_U: wrap_u     <= wrap_t'(cfg_data[1:0]);
        REG_WRAP_V: wrap_v     <= wrap_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  logic [SXW-1:0] w_eff;
  logic [SYW-1:0] h_eff;
  logic [XW-1:0]  wm;
  logic [YW-1:0]  hm;

  always_comb begin
    if (tex_width == '0) w_eff = SXW'(1);
    else if (CW'(tex_width) > CW'(MAX_WIDTH)) w_eff = SXW'(MAX_WIDTH);
    else w_eff = SXW'(tex_width);
    if (tex_height == '0) h_eff = SYW'(1);
    else if (CH'(tex_height) > CH'(MAX_HEIGHT)) h_eff = SYW'(MAX_HEIGHT);
    else h_eff = SYW'(tex_height);
    wm = XW'(w_eff - SXW'(1));
    hm = YW'(h_eff - SYW'(1));
  end

  function automatic logic [16:0] wrap_fn(input coord_t c, input wrap_t mode);
    logic [16:0] m;
    logic [17:0] r;
    m = c[16:0];
    r = 18'h20000 - {1'b0, m};
    case (mode)
      WRAP_REPEAT: wrap_fn = {1'b0, c[15:0]};
      WRAP_MIRROR: wrap_fn = m[16] ? r[16:0] : m;
      default: begin
        if (c[23]) wrap_fn = '0;
        else if (c > coord_t'(ONE_Q16)) wrap_fn = ONE_Q16;
        else wrap_fn = c[16:0];
      end
    endcase
  endfunction

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: wrap
  logic        smp1, wr1, near1;
  logic [16:0] wu1, wv1;
  logic [15:0] idx1;
  logic [31:0] rgba1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp1 <= 1'b0;
      wr1  <= 1'b0;
    end else if (en) begin
      smp1 <= in_ch.valid && (op_t'(in_ch.op) == OP_NEAREST ||
                              op_t'(in_ch.op) == OP_BILIN);
      wr1  <= in_ch.valid && op_t'(in_ch.op) == OP_WRITE &&
              {16'b0, in_ch.texel_index} < 32'(DEPTH);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      near1 <= op_t'(in_ch.op) == OP_NEAREST;
      wu1   <= wrap_fn(in_ch.u_coord, wrap_u);
      wv1   <= wrap_fn(in_ch.v_coord, wrap_v);
      idx1  <= in_ch.texel_index;
      rgba1 <= in_ch.texel_rgba;
    end
  end

  // stage 2: scale by size minus one
  logic              smp2, wr2, near2;
  logic [17+XW-1:0]  px2;
  logic [17+YW-1:0]  py2;
  logic [15:0]       idx2;
  logic [31:0]       rgba2;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp2 <= 1'b0;
      wr2  <= 1'b0;
    end else if (en) begin
      smp2 <= smp1;
      wr2  <= wr1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      near2 <= near1;
      px2   <= (17+XW)'(wu1) * (17+XW)'(wm);
      py2   <= (17+YW)'(wv1) * (17+YW)'(hm);
      idx2  <= idx1;
      rgba2 <= rgba1;
    end
  end

  // stage 3: row base, neighbors, weights
  logic [XW-1:0] xi2;
  logic [YW-1:0] yi2;
  assign xi2 = px2[16 +: XW];
  assign yi2 = py2[16 +: YW];

  logic          smp3, wr3, near3, yinc3;
  logic [AW-1:0] row3;
  logic [XW-1:0] xa3, xb3;
  logic [7:0]    s3, t3;
  logic [15:0]   idx3;
  logic [31:0]   rgba3;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp3 <= 1'b0;
      wr3  <= 1'b0;
    end else if (en) begin
      smp3 <= smp2;
      wr3  <= wr2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      near3 <= near2;
      row3  <= AW'(AW'(yi2) * AW'(w_eff));
      xa3   <= xi2;
      xb3   <= (xi2 < wm) ? XW'(xi2 + XW'(1)) : xi2;
      yinc3 <= yi2 < hm;
      s3    <= near2 ? 8'd0 : px2[15:8];
      t3    <= near2 ? 8'd0 : py2[15:8];
      idx3  <= idx2;
      rgba3 <= rgba2;
    end
  end

  // stage 4: texel fetch
  logic [AW-1:0] row_lo, a11, a12, a21, a22;
  assign row_lo = yinc3 ? AW'(row3 + AW'(w_eff)) : row3;
  assign a11 = AW'(row3 + AW'(xa3));
  assign a12 = AW'(row3 + AW'(xb3));
  assign a21 = AW'(row_lo + AW'(xa3));
  assign a22 = AW'(row_lo + AW'(xb3));

  logic          we;
  logic [AW-1:0] waddr;
  assign we    = en && wr3;
  assign waddr = AW'(idx3);

  logic [31:0] c11, c12, c21, c22;

  tsw_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram_top (
    .clk, .we, .waddr, .wdata(rgba3), .re(en),
    .raddr_a(a11), .raddr_b(a12), .rdata_a(c11), .rdata_b(c12)
  );
  tsw_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram_bot (
    .clk, .we, .waddr, .wdata(rgba3), .re(en),
    .raddr_a(a21), .raddr_b(a22), .rdata_a(c21), .rdata_b(c22)
  );

  logic       smp4, near4;
  logic [7:0] s4, t4;
  always_ff @(posedge clk) begin
    if (rst) smp4 <= 1'b0;
    else if (en) smp4 <= smp3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      near4 <= near3;
      s4    <= s3;
      t4    <= t3;
    end
  end

  // stage 5: horizontal blend
  logic [8:0]  sn4;
  logic [15:0] top_next [4];
  logic [15:0] bot_next [4];
  assign sn4 = 9'd256 - {1'b0, s4};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      top_next[k] = 16'(17'(c11[8*k +: 8]) * 17'(sn4) + 17'(c12[8*k +: 8]) * 17'(s4));
      bot_next[k] = 16'(17'(c21[8*k +: 8]) * 17'(sn4) + 17'(c22[8*k +: 8]) * 17'(s4));
    end
  end

  logic        smp5;
  logic [7:0]  t5;
  logic [15:0] top5 [4];
  logic [15:0] bot5 [4];
  always_ff @(posedge clk) begin
    if (rst) smp5 <= 1'b0;
    else if (en) smp5 <= smp4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t5   <= t4;
      top5 <= top_next;
      bot5 <= bot_next;
    end
  end

  // stage 6: vertical blend and round into the output register
  logic [8:0]  tn5;
  logic [7:0]  chan_next [4];
  logic [25:0] acc;
  assign tn5 = 9'd256 - {1'b0, t5};

  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = 26'(top5[k]) * 26'(tn5) + 26'(bot5[k]) * 26'(t5) + 26'd32768;
      chan_next[k] = acc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= smp5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.alpha <= chan_next[0];
      out_ch.blue  <= chan_next[1];
      out_ch.green <= chan_next[2];
      out_ch.red   <= chan_next[3];
    end
  end

  `TSW_ASSERT_NEXT(a_fetch_follows, en && smp3, smp4)
  `TSW_ASSERT_NEXT(a_stall_holds, !en, $stable(smp4) && $stable(smp5))
  `TSW_ASSERT_NOW(a_nearest_unweighted, smp4 && near4, s4 == 8'd0 && t4 == 8'd0)
  `TSW_ASSERT_NOW(a_no_write_on_stall, we, en && !smp3)
endmodule

/* hdl/tsw_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module tsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

/* tb/tb_top.sv */
// Self-checking bench for the texture sampler: loads texels, sweeps sizes and
// wrap modes, and checks nearest and bilinear samples against a local model.
// Depends on tsw_pkg, tsw_in_if, tsw_out_if and texture_sample_wrap_bilinear.
module tb_top;
  import tsw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MEM_DEPTH      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct {
    op_t         op;
    logic [15:0] index;
    logic [31:0] rgba;
    logic [23:0] u;
    logic [23:0] v;
  } beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  tsw_in_if  in_ch ();
  tsw_out_if out_ch ();

  texture_sample_wrap_bilinear i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  beat_t       pending_beats[$];
  logic [31:0] expected_rgba[$];
  logic [31:0] texel_copy [MEM_DEPTH];
  bit          texel_loaded [MEM_DEPTH];
  logic [8:0]  width_reg, height_reg;
  logic [1:0]  wrap_u_reg, wrap_v_reg;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_go;
  int          mismatches;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] wrap_coord(logic [23:0] c, logic [1:0] mode);
    logic [16:0] m;
    case (wrap_t'(mode))
      WRAP_REPEAT: wrap_coord = {1'b0, c[15:0]};
      WRAP_MIRROR: begin
        m = c[16:0];
        wrap_coord = (m < ONE_Q16) ? m : 17'(18'h20000 - 18'(m));
      end
      default: begin
        if ($signed(c) < 0) wrap_coord = '0;
        else if (c > 24'h010000) wrap_coord = ONE_Q16;
        else wrap_coord = c[16:0];
      end
    endcase
  endfunction

  function automatic int unsigned eff_size(logic [8:0] r);
    if (r == 0) return 1;
    return (r > 256) ? 256 : r;
  endfunction

  function automatic logic [31:0] filter_sample(beat_t b);
    int unsigned w, h, px, py, xi, yi, s, t, x2, y2;
    int unsigned ca, cb, cc, cd, top, bot, ch;
    logic [31:0] t11, t12, t21, t22, res;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    px = wrap_coord(b.u, wrap_u_reg) * (w - 1);
    py = wrap_coord(b.v, wrap_v_reg) * (h - 1);
    xi = px >> 16;
    yi = py >> 16;
    t11 = texel_copy[yi * w + xi];
    if (b.op == OP_NEAREST) return t11;
    s = (px >> 8) & 8'hff;
    t = (py >> 8) & 8'hff;
    x2 = (xi + 1 < w) ? xi + 1 : w - 1;
    y2 = (yi + 1 < h) ? yi + 1 : h - 1;
    t12 = texel_copy[yi * w + x2];
    t21 = texel_copy[y2 * w + xi];
    t22 = texel_copy[y2 * w + x2];
    res = '0;
    for (int sh = 24; sh >= 0; sh -= 8) begin
      ca = (t11 >> sh) & 8'hff;
      cb = (t12 >> sh) & 8'hff;
      cc = (t21 >> sh) & 8'hff;
      cd = (t22 >> sh) & 8'hff;
      top = ca * (256 - s) + cb * s;
      bot = cc * (256 - s) + cd * s;
      ch = (top * (256 - t) + bot * t + 32768) >> 16;
      res |= (ch & 8'hff) << sh;
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    beat_t nb;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nb.op = op_t'(in_ch.op);
        nb.index = in_ch.texel_index;
        nb.rgba = in_ch.texel_rgba;
        nb.u = in_ch.u_coord;
        nb.v = in_ch.v_coord;
        if (nb.op == OP_WRITE) texel_copy[nb.index] = nb.rgba;
        else if (nb.op != OP_NONE) expected_rgba.push_back(filter_sample(nb));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = pending_beats.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.op          <= nb.op;
          in_ch.texel_index <= nb.index;
          in_ch.texel_rgba  <= nb.rgba;
          in_ch.u_coord     <= nb.u;
          in_ch.v_coord     <= nb.v;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [31:0] got, want;
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha};
        if (expected_rgba.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", got);
        end else begin
          want = expected_rgba.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rgba mismatch: expected %h actual %h", want, got);
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_left = 300;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_beat(op_t op, logic [15:0] idx, logic [31:0] rgba,
                           logic [23:0] u, logic [23:0] v);
    beat_t b;
    b.op = op;
    b.index = idx;
    b.rgba = rgba;
    b.u = u;
    b.v = v;
    if (op == OP_WRITE) texel_loaded[idx] = 1'b1;
    pending_beats.push_back(b);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      REG_WRAP_U: wrap_u_reg = val[1:0];
      default:    wrap_v_reg = val[1:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_ch.valid || expected_rgba.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup_phase(logic [8:0] w, logic [8:0] h, logic [1:0] wu,
                             logic [1:0] wv, int sp, int rp);
    int unsigned area;
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WRAP_U, CFG_DW'(wu));
    write_reg(REG_WRAP_V, CFG_DW'(wv));
    send_idle_pct = sp;
    recv_idle_pct = rp;
    area = eff_size(w) * eff_size(h);
    for (int unsigned a = 0; a < area; a++)
      if (!texel_loaded[a]) push_beat(OP_WRITE, 16'(a), $urandom(), '0, '0);
  endtask

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(1)) return 24'($urandom());
    return 24'($urandom_range(24'h60000) - 24'h30000);
  endfunction

  task automatic random_beats(int n);
    int unsigned area, sel;
    area = eff_size(width_reg) * eff_size(height_reg);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 35) push_beat(OP_NEAREST, '0, '0, rand_coord(), rand_coord());
      else if (sel < 72) push_beat(OP_BILIN, '0, '0, rand_coord(), rand_coord());
      else if (sel < 85)
        push_beat(OP_WRITE, 16'($urandom_range(area - 1)), $urandom(), '0, '0);
      else if (sel < 95)
        push_beat(OP_WRITE, 16'($urandom()), $urandom(), 24'($urandom()),
                  24'($urandom()));
      else
        push_beat(OP_NONE, 16'($urandom()), $urandom(), 24'($urandom()),
                  24'($urandom()));
    end
  endtask

  initial begin
    logic [23:0] edge_coords[8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NONE;
    in_ch.texel_index = '0;
    in_ch.texel_rgba = '0;
    in_ch.u_coord = '0;
    in_ch.v_coord = '0;
    out_ch.ready = 1'b0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    wrap_u_reg = WRAP_REPEAT;
    wrap_v_reg = WRAP_REPEAT;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b0;
    mismatches = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    edge_coords = '{24'h800000, 24'h7fffff, 24'h000000, 24'h010000,
                    24'h00ffff, 24'h020000, 24'hffffff, 24'h018000};
    setup_phase(9'd4, 9'd3, WRAP_REPEAT, WRAP_MIRROR, 0, 0);
    push_beat(OP_WRITE, 16'hffff, 32'hffffffff, 24'hffffff, 24'hffffff);
    push_beat(OP_WRITE, 16'd0, 32'h00000000, '0, '0);
    push_beat(OP_WRITE, 16'd11, 32'hffffffff, '0, '0);
    push_beat(OP_NONE, 16'hffff, 32'hffffffff, 24'hffffff, 24'hffffff);
    for (int i = 0; i < 8; i++) begin
      push_beat(OP_NEAREST, '0, '0, edge_coords[i], edge_coords[7 - i]);
      push_beat(OP_BILIN, '0, '0, edge_coords[i], edge_coords[(i + 3) % 8]);
    end
    setup_phase(9'd8, 9'd8, WRAP_CLAMP, WRAP_MIRROR, 0, 0);
    random_beats(30);
    setup_phase(9'd1, 9'd1, WRAP_CLAMP3, WRAP_CLAMP3, 69, 0);
    random_beats(20);
    setup_phase(9'd0, 9'd511, WRAP_MIRROR, WRAP_REPEAT, 0, 69);
    hold_go = 1'b1;
    random_beats(30);
    setup_phase(9'd128, 9'd2, WRAP_REPEAT, WRAP_CLAMP, 21, 21);
    random_beats(25);
    setup_phase(9'd300, 9'd1, WRAP_MIRROR, WRAP_CLAMP, 21, 21);
    random_beats(25);
    setup_phase(9'd7, 9'd5, 2'($urandom_range(3)), 2'($urandom_range(3)), 0, 0);
    random_beats(20);
    wait_idle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* texture_sample_wrap_bilinear.f */
+incdir+hdl
hdl/tsw_pkg.sv
hdl/tsw_in_if.sv
hdl/tsw_out_if.sv
hdl/tsw_ram.sv
hdl/texture_sample_wrap_bilinear.sv
tb/tb_top.sv
